>>> design/orp_trimmed_window_average_macros.svh
// Assertion macros used by the checker file of the ORP trimmed average block.
`ifndef ORP_TRIMMED_WINDOW_AVERAGE_MACROS_SVH
`define ORP_TRIMMED_WINDOW_AVERAGE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define ORP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define ORP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/orp_twa_pkg.sv
// Shared constants and control types of the ORP trimmed window average block.
`default_nettype none

package orp_twa_pkg;

	// Window and sample geometry
	localparam int WINDOW_LENGTH = 40;
	localparam int SAMPLE_W      = 10;
	localparam int ADC_FULL      = 1023;
	localparam int IDX_W         = $clog2(WINDOW_LENGTH);
	localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
	localparam int TOTAL_W       = $clog2(WINDOW_LENGTH * ADC_FULL + 1);

	// Potential conversion: x = trunc((2000*DEN - 5000*sum) / DEN) - offset
	localparam int DEN        = (WINDOW_LENGTH - 2) * ADC_FULL;
	localparam int SCALE_MV   = 5000;
	localparam int PROD_W     = $clog2(SCALE_MV * DEN + 1);
	localparam int QUO_W      = $clog2(SCALE_MV + 1);
	localparam int X_HIGH     = 2000;
	localparam int X_LOW      = -3000;
	localparam int OUT_LOW    = -2000;
	localparam int X_W        = 14;

	// Quotient estimate: floor(sum * RECIP_DEN / 2^DIV_SH) is exact or one low
	localparam int DIV_SH     = 24;
	localparam int RECIP_DEN  = int'((longint'(SCALE_MV) << DIV_SH) / longint'(DEN));
	localparam int RECIP_W    = $clog2(RECIP_DEN + 1);
	localparam int EST_W      = TOTAL_W + RECIP_W;
	localparam int DIV_STEPS  = 3;
	localparam int QCNT_W     = $clog2(DIV_STEPS);

	// Output mapping: (x - X_LOW) * 4 / 5, divide by 5 through a reciprocal
	localparam int SPAN_W     = 15;
	localparam int RECIP5     = 52429;
	localparam int RECIP_SH   = 18;
	localparam int MAP_W      = 31;

	// Port field widths
	localparam int OFF_W      = 10;
	localparam int ORP_W      = 12;
	localparam int TSUM_W     = 16;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic walk;
		logic trim;
		logic div_init;
		logic div_step;
		logic conv;
		logic map;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic walk_done;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> design/orp_twa_dp.sv
// Datapath: sample ring, trimmed sum walk, divider, mapping and output register.
`default_nettype none

module orp_twa_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire orp_twa_pkg::cmd_t                      cmd,
	input  wire logic [orp_twa_pkg::SAMPLE_W-1:0]       sample,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [orp_twa_pkg::OFF_W-1:0]          cfg_data,
	input  wire logic                                   m_tready,
	output logic                                        m_tvalid,
	output logic [orp_twa_pkg::M_TDATA_W-1:0]           m_tdata,
	output orp_twa_pkg::stat_t                          stat
);

	localparam int PAD_W = orp_twa_pkg::M_TDATA_W - orp_twa_pkg::TSUM_W - orp_twa_pkg::ORP_W;

	// Ring storage and its valid bits
	logic [orp_twa_pkg::SAMPLE_W-1:0]      mem [orp_twa_pkg::WINDOW_LENGTH];
	logic [orp_twa_pkg::WINDOW_LENGTH-1:0] valid_q;
	logic [orp_twa_pkg::IDX_W-1:0]         wr_pos_q;

	// Walk
	logic [orp_twa_pkg::CNT_W-1:0]         rd_cnt_q;
	logic                                  rd_issue;
	logic                                  pend_s1;
	logic [orp_twa_pkg::SAMPLE_W-1:0]      rd_data_s1;
	logic                                  rd_valid_s1;
	logic [orp_twa_pkg::SAMPLE_W-1:0]      rd_val;
	logic [orp_twa_pkg::TOTAL_W-1:0]       total_q;
	logic [orp_twa_pkg::SAMPLE_W-1:0]      lo_q;
	logic [orp_twa_pkg::SAMPLE_W-1:0]      hi_q;
	logic [orp_twa_pkg::TOTAL_W-1:0]       trim_q;

	// Divider
	logic [orp_twa_pkg::EST_W-1:0]         est_q;
	logic [orp_twa_pkg::PROD_W-1:0]        num_q;
	logic [orp_twa_pkg::PROD_W-1:0]        rem_q;
	logic [orp_twa_pkg::QUO_W-1:0]         quo_q;
	logic [orp_twa_pkg::QCNT_W-1:0]        div_cnt_q;

	// Conversion and mapping
	logic signed [orp_twa_pkg::OFF_W-1:0]  offset_q;
	logic                                  corr;
	logic signed [orp_twa_pkg::X_W-1:0]    x_raw;
	logic signed [orp_twa_pkg::X_W-1:0]    x_sat;
	logic signed [orp_twa_pkg::X_W-1:0]    x_span;
	logic [orp_twa_pkg::SPAN_W-1:0]        span_q;
	logic [orp_twa_pkg::MAP_W-1:0]         prod_q;
	logic [orp_twa_pkg::ORP_W-1:0]         orp_val;

	// Output register
	logic                                  out_valid_q;
	logic [orp_twa_pkg::M_TDATA_W-1:0]     out_data_q;

	assign cfg_ready = 1'b1;
	assign rd_issue  = cmd.walk && (rd_cnt_q != orp_twa_pkg::CNT_W'(orp_twa_pkg::WINDOW_LENGTH));
	assign rd_val    = rd_valid_s1 ? rd_data_s1 : '0;

	// Offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	// Write the new sample, read one entry per walk step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_pos_q] <= sample;
		end
		if (rd_issue) begin
			rd_data_s1  <= mem[rd_cnt_q[orp_twa_pkg::IDX_W-1:0]];
			rd_valid_s1 <= valid_q[rd_cnt_q[orp_twa_pkg::IDX_W-1:0]];
		end
	end

	// Advance write position, valid bits and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			wr_pos_q <= '0;
			rd_cnt_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.load) begin
			valid_q[wr_pos_q] <= 1'b1;
			if (wr_pos_q == orp_twa_pkg::IDX_W'(orp_twa_pkg::WINDOW_LENGTH - 1)) begin
				wr_pos_q <= '0;
			end else begin
				wr_pos_q <= wr_pos_q + 1'b1;
			end
			rd_cnt_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= rd_issue;
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// Accumulate total, minimum and maximum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			total_q <= '0;
			lo_q    <= orp_twa_pkg::SAMPLE_W'(orp_twa_pkg::ADC_FULL);
			hi_q    <= '0;
		end else if (pend_s1) begin
			total_q <= total_q + orp_twa_pkg::TOTAL_W'(rd_val);
			if (rd_val < lo_q) begin
				lo_q <= rd_val;
			end
			if (rd_val > hi_q) begin
				hi_q <= rd_val;
			end
		end
	end

	// Drop one minimum and one maximum
	always_ff @(posedge clk) begin
		if (cmd.trim) begin
			trim_q <= total_q - orp_twa_pkg::TOTAL_W'(lo_q) - orp_twa_pkg::TOTAL_W'(hi_q);
		end
	end

	// Divide 5000*sum by DEN: estimate by reciprocal, back-multiply, fix up by one
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			est_q <= orp_twa_pkg::EST_W'(trim_q) * orp_twa_pkg::EST_W'(orp_twa_pkg::RECIP_DEN);
			num_q <= orp_twa_pkg::PROD_W'(trim_q) * orp_twa_pkg::PROD_W'(orp_twa_pkg::SCALE_MV);
		end else if (cmd.div_step) begin
			if (div_cnt_q == orp_twa_pkg::QCNT_W'(orp_twa_pkg::DIV_STEPS - 1)) begin
				quo_q <= est_q[orp_twa_pkg::DIV_SH+orp_twa_pkg::QUO_W-1:orp_twa_pkg::DIV_SH];
			end else if (div_cnt_q != '0) begin
				rem_q <= num_q
					- orp_twa_pkg::PROD_W'(quo_q) * orp_twa_pkg::PROD_W'(orp_twa_pkg::DEN);
			end else if (rem_q >= orp_twa_pkg::PROD_W'(orp_twa_pkg::DEN)) begin
				rem_q <= rem_q - orp_twa_pkg::PROD_W'(orp_twa_pkg::DEN);
				quo_q <= quo_q + 1'b1;
			end
		end
	end

	// Count divide steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= orp_twa_pkg::QCNT_W'(orp_twa_pkg::DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// Truncate toward zero, subtract offset, saturate
	always_comb begin
		corr   = (rem_q != '0) && (quo_q < orp_twa_pkg::QUO_W'(orp_twa_pkg::X_HIGH));
		x_raw  = orp_twa_pkg::X_W'(orp_twa_pkg::X_HIGH) - orp_twa_pkg::X_W'(quo_q)
			- orp_twa_pkg::X_W'(corr) - orp_twa_pkg::X_W'(offset_q);
		if (x_raw < orp_twa_pkg::X_W'(orp_twa_pkg::X_LOW)) begin
			x_sat = orp_twa_pkg::X_W'(orp_twa_pkg::X_LOW);
		end else if (x_raw > orp_twa_pkg::X_W'(orp_twa_pkg::X_HIGH)) begin
			x_sat = orp_twa_pkg::X_W'(orp_twa_pkg::X_HIGH);
		end else begin
			x_sat = x_raw;
		end
		x_span = x_sat - orp_twa_pkg::X_W'(orp_twa_pkg::X_LOW);
	end

	// Hold four times the span above the low limit, then scale by one fifth
	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			span_q <= orp_twa_pkg::SPAN_W'($unsigned(x_span)) << 2;
		end
		if (cmd.map) begin
			prod_q <= orp_twa_pkg::MAP_W'(span_q) * orp_twa_pkg::MAP_W'(orp_twa_pkg::RECIP5);
		end
	end

	assign orp_val = orp_twa_pkg::ORP_W'(prod_q[orp_twa_pkg::MAP_W-1:orp_twa_pkg::RECIP_SH])
		+ orp_twa_pkg::ORP_W'(orp_twa_pkg::OUT_LOW);

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {PAD_W'(0), orp_twa_pkg::TSUM_W'(trim_q), orp_val};
		end
	end

	assign m_tvalid       = out_valid_q;
	assign m_tdata        = out_data_q;
	assign stat.walk_done = (rd_cnt_q == orp_twa_pkg::CNT_W'(orp_twa_pkg::WINDOW_LENGTH)) && !pend_s1;
	assign stat.div_last  = (div_cnt_q == '0);
	assign stat.out_free  = !out_valid_q || m_tready;

endmodule

`default_nettype wire

>>> design/orp_twa_ctrl.sv
// Controller: sequences accept, ring walk, divide, conversion and result hand-off.
`default_nettype none

module orp_twa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire orp_twa_pkg::stat_t  stat,
	output orp_twa_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_TRIM,
		ST_DIV_INIT,
		ST_DIV,
		ST_CONV,
		ST_MAP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   s_tready_q;

	assign s_tready = s_tready_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.load     = s_tvalid && s_tready_q;
			ST_WALK:     cmd.walk     = 1'b1;
			ST_TRIM:     cmd.trim     = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_CONV:     cmd.conv     = 1'b1;
			ST_MAP:      cmd.map      = 1'b1;
			ST_EMIT:     cmd.emit     = stat.out_free;
			default:     cmd          = '0;
		endcase
	end

	// Advance state, hold input ready while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready_q) begin
						state_q    <= ST_WALK;
						s_tready_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (stat.walk_done) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM:     state_q <= ST_DIV_INIT;
				ST_DIV_INIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV:     state_q <= ST_MAP;
				ST_MAP:      state_q <= ST_EMIT;
				ST_EMIT: begin
					if (stat.out_free) begin
						state_q    <= ST_IDLE;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					s_tready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/orp_trimmed_window_average.sv
// Top level of the ORP trimmed window average block.
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one 10-bit ADC sample per
// request. Each sample is written into a 40-entry ring; the ring is then
// summed with one minimum and one maximum dropped, converted to a potential
// in millivolts, offset-corrected, saturated and mapped to -2000..2000.
// Output stream (m_tvalid/m_tready/m_tdata) carries one result per sample.
// The cfg channel writes the signed zero-drift offset; write it while idle.
// The result is registered; the block takes no new sample until the previous
// result has been loaded into the output register. The walk reads one ring
// entry per cycle through the single memory read port, followed by trim, a
// three-step reciprocal divide, conversion and mapping.
// Reset clears the ring's valid bits (unwritten entries read as zero), the write position and the offset.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and processed, and its result waits until the
// output register is free.
`default_nettype none

module orp_trimmed_window_average (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// s_tdata: [9:0] sample
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [orp_twa_pkg::S_TDATA_W-1:0]    s_tdata,
	// m_tdata: [11:0] orp_mv, [27:12] trimmed_sum
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [orp_twa_pkg::M_TDATA_W-1:0]         m_tdata,
	// cfg_data: offset_mv
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [orp_twa_pkg::OFF_W-1:0]        cfg_data
);

	orp_twa_pkg::cmd_t  cmd;
	orp_twa_pkg::stat_t stat;

	orp_twa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	orp_twa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (s_tdata[orp_twa_pkg::SAMPLE_W-1:0]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.stat      (stat)
	);

endmodule

`default_nettype wire

>>> design/orp_twa_checker.sv
// Port-level checker for the ORP trimmed window average block, with its bind.
`default_nettype none

`include "orp_trimmed_window_average_macros.svh"

module orp_twa_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	input  wire logic                                 s_tready,
	input  wire logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic [orp_twa_pkg::M_TDATA_W-1:0]    m_tdata
);

	// A stalled result holds
	`ORP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// One sample at a time: ready drops after each request
	`ORP_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

	// Mapped potential stays within its range
	`ORP_ASSERT_NOW(a_orp_range, m_tvalid, ($signed(m_tdata[11:0]) >= -12'sd2000) && ($signed(m_tdata[11:0]) <= 12'sd2000), "orp_mv out of range")

	// Trimmed sum never exceeds the full-scale trimmed window
	`ORP_ASSERT_NOW(a_sum_range, m_tvalid, m_tdata[27:12] <= 16'd38874, "trimmed_sum out of range")

endmodule

bind orp_trimmed_window_average orp_twa_checker u_orp_twa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the ORP trimmed window average: directed and random samples and offsets vs. a predictor.

module testbench;
	import orp_twa_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 2500;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 190;

	typedef struct packed {
		logic [ORP_W-1:0]  orp_mv;
		logic [TSUM_W-1:0] trimmed_sum;
	} reading_t;

	typedef enum int {PAT_FLAT, PAT_FULL, PAT_ZERO, PAT_JITTER, PAT_TOGGLE, PAT_EDGES,
		PAT_UNIFORM} pattern_e;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;   // [9:0] sample
	logic                 m_tvalid;
	logic                 m_tready  = 1'b1;
	logic [M_TDATA_W-1:0] m_tdata;          // [11:0] orp_mv, [27:12] trimmed_sum
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [OFF_W-1:0]     cfg_data  = '0;   // offset_mv

	// Predictor copy of the window, write slot and offset register
	logic [SAMPLE_W-1:0]     ring_copy [WINDOW_LENGTH];
	int unsigned             wr_slot    = 0;
	logic signed [OFF_W-1:0] offset_now = '0;

	logic [SAMPLE_W-1:0] samples_pending [$];
	reading_t            readings_due [$];

	bit          idle_on       = 1'b1;
	bit          long_hold     = 1'b0;
	int          src_gap       = 0;
	int          sink_gap      = 0;
	int unsigned samples_taken = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned error_count   = 0;

	orp_trimmed_window_average u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Generate the 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count and print one mismatch
	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	// Write one sample into the window and queue the reading it yields
	task automatic absorb_sample(input logic [SAMPLE_W-1:0] smp);
		longint   total, lo, hi, trimmed, den, x, mapped;
		reading_t r;
		total = 0;
		lo    = ADC_FULL;
		hi    = 0;
		ring_copy[wr_slot] = smp;
		wr_slot = (wr_slot == WINDOW_LENGTH - 1) ? 0 : wr_slot + 1;
		foreach (ring_copy[i]) begin
			total += ring_copy[i];
			if (ring_copy[i] < lo)
				lo = ring_copy[i];
			if (ring_copy[i] > hi)
				hi = ring_copy[i];
		end
		// drop a single minimum and a single maximum, even when values repeat
		trimmed = total - lo - hi;
		den     = longint'(WINDOW_LENGTH - 2) * ADC_FULL;
		x       = (longint'(X_HIGH) * den - longint'(SCALE_MV) * trimmed) / den;
		x       = x - longint'(offset_now);
		if (x < X_LOW)
			x = X_LOW;
		if (x > X_HIGH)
			x = X_HIGH;
		// map -3000..2000 onto -2000..2000
		mapped = (x - X_LOW) * (-2 * OUT_LOW) / (X_HIGH - X_LOW) + OUT_LOW;
		r.orp_mv      = mapped[ORP_W-1:0];
		r.trimmed_sum = trimmed[TSUM_W-1:0];
		readings_due.push_back(r);
	endtask

	// Block until no request is pending or in flight
	task automatic await_idle();
		while (samples_pending.size() != 0 || s_tvalid || readings_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the offset register through the cfg channel
	task automatic write_offset(input logic signed [OFF_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		offset_now = v;
	endtask

	// Queue a window-filling run, then runs of patterned and random samples
	task automatic queue_random(input int count, input logic [SAMPLE_W-1:0] fill);
		int                  k, j, run, pick;
		pattern_e            pat;
		logic [SAMPLE_W-1:0] base, v;
		for (j = 0; j < WINDOW_LENGTH + 2; j++)
			samples_pending.push_back(fill);
		k = 0;
		while (k < count) begin
			pick = $urandom_range(0, 9);
			pat  = (pick > PAT_UNIFORM) ? PAT_UNIFORM : pattern_e'(pick);
			base = SAMPLE_W'($urandom);
			if (pat == PAT_FULL || pat == PAT_ZERO)
				run = $urandom_range(WINDOW_LENGTH, WINDOW_LENGTH + 20);
			else
				run = $urandom_range(1, WINDOW_LENGTH);
			for (j = 0; j < run; j++) begin
				case (pat)
					PAT_FLAT:   v = base;
					PAT_FULL:   v = SAMPLE_W'(ADC_FULL);
					PAT_ZERO:   v = '0;
					PAT_JITTER: v = base ^ SAMPLE_W'($urandom_range(0, 7));
					PAT_TOGGLE: v = j[0] ? SAMPLE_W'(ADC_FULL) : '0;
					PAT_EDGES: begin
						if ($urandom_range(0, 2) == 0)
							v = $urandom_range(0, 1) ? SAMPLE_W'(ADC_FULL) : '0;
						else
							v = SAMPLE_W'($urandom);
					end
					default:    v = SAMPLE_W'($urandom);
				endcase
				samples_pending.push_back(v);
				k++;
			end
		end
	endtask

	// Drive sample requests from the pending queue, with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				absorb_sample(s_tdata[SAMPLE_W-1:0]);
				samples_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (samples_pending.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 15);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata  <= S_TDATA_W'(samples_pending.pop_front());
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Check each result request against the oldest predicted reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("unexpected result, orp_mv", $signed(m_tdata[11:0]), 0);
				end else begin
					want = readings_due.pop_front();
					if (m_tdata[11:0] !== want.orp_mv)
						report_mismatch("orp_mv", $signed(m_tdata[11:0]), $signed(want.orp_mv));
					if (m_tdata[27:12] !== want.trimmed_sum)
						report_mismatch("trimmed_sum", m_tdata[27:12], want.trimmed_sum);
				end
			end
			// stall the result side in random bursts
			if (long_hold) begin
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hold off the receiver for a long stretch so the block backs up
	initial begin
		wait (samples_taken >= 300);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Abort when no request moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[orp_trimmed_window_average] ERROR");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Sequence reset, directed samples and offset phases
	initial begin
		int offset_plan [6];
		int p;
		offset_plan = '{511, -512, -500, 500, 0, 0};
		offset_plan[4] = $urandom_range(0, 1023) - 512;
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: start-up zeros, field extremes, bit patterns, repeated extremes
		samples_pending = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd512, 10'd511, 10'd341,
			10'd682, 10'd1, 10'd1022, 10'd700, 10'd700, 10'd700, 10'd100, 10'd900,
			10'd1023, 10'd0, 10'd1023, 10'd3, 10'd1020};
		await_idle();

		// Random phases; the fill run pushes the potential to its saturation limit
		for (p = 0; p < 6; p++) begin
			write_offset(OFF_W'(offset_plan[p]));
			idle_on = (p != 5);
			queue_random(PHASE_ITEMS, (offset_plan[p] >= 0) ? SAMPLE_W'(ADC_FULL) : '0);
			await_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[orp_trimmed_window_average] OK");
		else
			$display("[orp_trimmed_window_average] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/orp_twa_pkg.sv
design/orp_twa_dp.sv
design/orp_twa_ctrl.sv
design/orp_trimmed_window_average.sv
design/orp_twa_checker.sv
test/testbench.sv
